FILE: sv/assert_macros.svh
// Assertion macros used by the checker file of the embedding bank.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property check, disabled while reset is asserted.
`define EBTK_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("embedding bank port check failed");

// A valid beat that is stalled must still be valid in the next cycle.
`define EBTK_ASSERT_HOLD(label, clk, rst_n, vld, stl) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (vld && stl) |=> vld) \
        else $error("embedding bank stalled beat dropped");

`endif

FILE: sv/ebtk_pkg.sv
// Package with sizes, codes and interface types of the embedding bank search.
`default_nettype none

package ebtk_pkg;

    localparam int MAX_DIM    = 512;
    localparam int ENTRIES    = 64;
    localparam int RESULT_CAP = 64;

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W  = $clog2(MAX_DIM + 1);
    localparam int ROW_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RCNT_W = $clog2(ENTRIES + 1);
    localparam int TAKE_W = (RCNT_W > 7) ? RCNT_W : 7;
    localparam int ACC_W  = 32 + CNT_W;
    localparam int SQ_W   = ((ACC_W + 17) / 2) * 2;
    localparam int ROOT_W = SQ_W / 2;
    localparam int SQC_W  = $clog2(ROOT_W + 1);
    localparam int NUM_W  = 41;
    localparam int DEN_W  = ROOT_W + 1;
    localparam int CMP_W  = ((NUM_W > DEN_W + 15) ? NUM_W : DEN_W + 15) + 1;
    localparam int RS_DEPTH = ENTRIES * (1 << IDX_W);

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_MATCH        = 3'd0,
        ST_ADDED        = 3'd1,
        ST_CLEARED      = 3'd2,
        ST_DIM_MISMATCH = 3'd3,
        ST_BANK_FULL    = 3'd4,
        ST_BANK_EMPTY   = 3'd5,
        ST_TOO_LONG     = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SUMSQ,
        S_SQRT,
        S_NRM_RD,
        S_NRM_DAT,
        S_NRM_DIV,
        S_NRM_WR,
        S_DOT_RUN,
        S_DOT_SAVE,
        S_RANK_SCAN,
        S_EMIT
    } ctl_state_t;

    typedef enum logic [1:0] {
        EK_STATUS,
        EK_ADDED,
        EK_MATCH
    } emit_kind_t;

    typedef struct packed {
        logic clr;
        logic vld;
    } mac_ctl_t;

    typedef struct packed {
        logic busy;
        logic sat;
    } div_stat_t;

endpackage

`default_nettype wire

FILE: sv/ebtk_mac.sv
// Shared multiply-accumulate unit for sums of squares and dot products.
`default_nettype none

module ebtk_mac
    import ebtk_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mac_ctl_t                ctl,
    input  logic signed [15:0]      a,
    input  logic signed [15:0]      b,
    output logic signed [ACC_W-1:0] acc,
    output logic                    busy
);

    logic signed [31:0]      prod_reg;
    logic                    pv_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clr)
        begin
            acc_next = '0;
        end
        else if (pv_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg  <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            pv_reg  <= ctl.vld;
            acc_reg <= acc_next;
        end
    end

    assign acc  = acc_reg;
    assign busy = pv_reg;

endmodule

`default_nettype wire

FILE: sv/ebtk_sqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
`default_nettype none

module ebtk_sqrt
    import ebtk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SQ_W-1:0]   val,
    output logic [ROOT_W-1:0] root,
    output logic              busy
);

    logic [SQ_W-1:0]  v_reg;
    logic [SQ_W-1:0]  res_reg;
    logic [SQ_W-1:0]  bit_reg;
    logic [SQC_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [SQ_W-1:0]  trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            res_reg  <= '0;
            bit_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            v_reg    <= val;
            res_reg  <= '0;
            bit_reg  <= SQ_W'(1) << (SQ_W - 2);
            cnt_reg  <= SQC_W'(ROOT_W);
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg  <= bit_reg >> 2;
            cnt_reg  <= cnt_reg - SQC_W'(1);
            busy_reg <= (cnt_reg != SQC_W'(1));
        end
    end

    assign root = res_reg[ROOT_W-1:0];
    assign busy = busy_reg;

endmodule

`default_nettype wire

FILE: sv/ebtk_div.sv
// Restoring divider giving a 15-bit quotient with a saturation flag.
`default_nettype none

module ebtk_div
    import ebtk_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [14:0]      q,
    output div_stat_t        stat
);

    logic [CMP_W-1:0] rem_reg;
    logic [CMP_W-1:0] dsh_reg;
    logic [14:0]      q_reg;
    logic [3:0]       cnt_reg;
    logic             busy_reg;
    logic             sat_reg;
    logic [CMP_W-1:0] big;
    logic             ge;

    assign big = CMP_W'(den) << 15;
    assign ge  = (rem_reg >= dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            dsh_reg  <= '0;
            q_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            sat_reg  <= 1'b0;
        end
        else if (start)
        begin
            // A quotient of 2^15 or more only ever saturates.
            rem_reg  <= CMP_W'(num);
            dsh_reg  <= CMP_W'(den) << 14;
            q_reg    <= '0;
            cnt_reg  <= 4'd15;
            sat_reg  <= (CMP_W'(num) >= big);
            busy_reg <= (CMP_W'(num) < big);
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg    <= {q_reg[13:0], ge};
            dsh_reg  <= dsh_reg >> 1;
            cnt_reg  <= cnt_reg - 4'd1;
            busy_reg <= (cnt_reg != 4'd1);
        end
    end

    assign q         = q_reg;
    assign stat.busy = busy_reg;
    assign stat.sat  = sat_reg;

endmodule

`default_nettype wire

FILE: sv/embedding_bank_top_k_search.sv
// Top level of the embedding bank with cosine-similarity top-k search.
// Vectors stream in one Q8.8 element per input beat; a beat that does not close a vector does
// not stall the input. Closing an add vector runs the sum of squares on the shared
// multiply-accumulate unit, the bit-serial square root (ROOT_W steps and a handoff), and the
// restoring divider for each element, then ends the pass and hands over the result beat. A query
// takes the same normalization, then the dot products of all rows (one product per cycle
// through the multiply-accumulate unit and the row memory port), then a scan of the score
// memory for each match returned. Error, clear and empty-bank results skip these steps. A result
// beat that the receiver stalls holds back the next result until it is taken. No input is taken
// while a vector is processed. No clearing pass is needed after reset.
`default_nettype none

module embedding_bank_top_k_search
    import ebtk_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         operation,
    input  logic signed [15:0] element_value,
    input  logic               last_element,
    input  logic [6:0]         top_k,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic [5:0]         entry_index,
    output logic signed [15:0] score,
    output logic               last_result
);

    ctl_state_t state_reg, state_next;

    logic [CNT_W-1:0]  elem_cnt_reg, elem_cnt_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  dim_reg, dim_next;
    logic [RCNT_W-1:0] rows_reg, rows_next;
    logic [CNT_W-1:0]  vlen_reg, vlen_next;
    logic              vovf_reg, vovf_next;
    logic              isq_reg, isq_next;
    logic [6:0]        k_reg, k_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [RCNT_W-1:0] row_reg, row_next;
    logic              rdv_reg, rdv_next;
    logic              zero_reg, zero_next;
    logic              sign_reg, sign_next;
    logic [ENTRIES-1:0] taken_reg, taken_next;
    logic signed [15:0] best_reg, best_next;
    logic [ROW_W-1:0]  best_idx_reg, best_idx_next;
    logic              found_reg, found_next;
    logic [TAKE_W-1:0] t_reg, t_next;
    logic [TAKE_W-1:0] take_reg, take_next;
    logic              sbv_reg, sbv_next;
    logic [ROW_W-1:0]  sbi_reg, sbi_next;

    status_t           pend_st_reg, pend_st_next;
    logic [5:0]        pend_ei_reg, pend_ei_next;
    logic signed [15:0] pend_sc_reg, pend_sc_next;
    logic              pend_lr_reg, pend_lr_next;
    emit_kind_t        kind_reg, kind_next;

    logic              ov_reg, ov_next;
    logic [2:0]        st_reg, st_next;
    logic [5:0]        ei_reg, ei_next;
    logic signed [15:0] sc_reg, sc_next;
    logic              lr_reg, lr_next;

    // Staging vector memory; a query is normalized in place.
    logic [15:0]        stg_mem [MAX_DIM];
    logic               stg_we;
    logic [IDX_W-1:0]   stg_wa, stg_ra;
    logic [15:0]        stg_wd;
    logic [15:0]        stg_rd_reg;

    logic [15:0]              rs_mem [RS_DEPTH];
    logic                     rs_we;
    logic [ROW_W+IDX_W-1:0]   rs_wa, rs_ra;
    logic [15:0]              rs_rd_reg;

    logic signed [15:0] sb_mem [ENTRIES];
    logic               sb_we;
    logic [ROW_W-1:0]   sb_wa, sb_ra;
    logic signed [15:0] sb_rd_reg;

    mac_ctl_t                mac_ctl;
    logic signed [15:0]      mac_b;
    logic signed [ACC_W-1:0] mac_acc;
    logic                    mac_busy;

    logic              sqrt_start;
    logic [SQ_W-1:0]   sqrt_val;
    logic [ROOT_W-1:0] root;
    logic              sqrt_busy;

    logic             div_start;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic [14:0]      div_q;
    div_stat_t        div_stat;

    logic               in_acc;
    logic               out_free;
    logic               has_room;
    logic [15:0]        mag;
    logic signed [15:0] qv;
    logic signed [15:0] y;
    logic signed [ACC_W:0] rnd_v;
    logic signed [ACC_W:0] rnd_q;
    logic signed [15:0] score_rnd;
    logic [TAKE_W-1:0]  kx, rx, tk;

    ebtk_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a     ($signed(stg_rd_reg)),
        .b     (mac_b),
        .acc   (mac_acc),
        .busy  (mac_busy)
    );

    ebtk_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .val   (sqrt_val),
        .root  (root),
        .busy  (sqrt_busy)
    );

    ebtk_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .q     (div_q),
        .stat  (div_stat)
    );

    always_ff @(posedge clk)
    begin
        if (stg_we)
        begin
            stg_mem[stg_wa] <= stg_wd;
        end
        stg_rd_reg <= stg_mem[stg_ra];
    end

    always_ff @(posedge clk)
    begin
        if (rs_we)
        begin
            rs_mem[rs_wa] <= y;
        end
        rs_rd_reg <= rs_mem[rs_ra];
    end

    always_ff @(posedge clk)
    begin
        if (sb_we)
        begin
            sb_mem[sb_wa] <= score_rnd;
        end
        sb_rd_reg <= sb_mem[sb_ra];
    end

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !ov_reg || !out_stall;
    assign has_room = (elem_cnt_reg < CNT_W'(MAX_DIM));

    assign mac_b    = (state_reg == S_DOT_RUN) ? $signed(rs_rd_reg) : $signed(stg_rd_reg);
    assign sqrt_val = SQ_W'($unsigned(mac_acc)) << 16;

    assign mag     = stg_rd_reg[15] ? 16'(-stg_rd_reg) : stg_rd_reg;
    assign div_num = NUM_W'({mag, 24'd0}) + NUM_W'(root);
    assign div_den = {root, 1'b0};

    // Quotient to Q1.15, saturated; an all-zero vector stays zero.
    assign qv = $signed({1'b0, div_q});
    always_comb
    begin
        if (zero_reg)
        begin
            y = '0;
        end
        else if (div_stat.sat)
        begin
            y = sign_reg ? 16'sh8000 : 16'sh7fff;
        end
        else
        begin
            y = sign_reg ? -qv : qv;
        end
    end

    // Round the Q2.30 dot product to the nearest Q1.15 value, ties upward, then saturate.
    assign rnd_v = {mac_acc[ACC_W-1], mac_acc} + (ACC_W+1)'(16384);
    assign rnd_q = rnd_v >>> 15;
    always_comb
    begin
        if (rnd_q > (ACC_W+1)'(32767))
        begin
            score_rnd = 16'sh7fff;
        end
        else if (rnd_q < -(ACC_W+1)'(32768))
        begin
            score_rnd = 16'sh8000;
        end
        else
        begin
            score_rnd = rnd_q[15:0];
        end
    end

    assign kx = TAKE_W'(k_reg);
    assign rx = TAKE_W'(rows_reg);
    always_comb
    begin
        tk = ((kx == '0) || (kx > rx)) ? rx : kx;
        if (tk > TAKE_W'(RESULT_CAP))
        begin
            tk = TAKE_W'(RESULT_CAP);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        elem_cnt_next = elem_cnt_reg;
        ovf_next      = ovf_reg;
        dim_next      = dim_reg;
        rows_next     = rows_reg;
        vlen_next     = vlen_reg;
        vovf_next     = vovf_reg;
        isq_next      = isq_reg;
        k_next        = k_reg;
        idx_next      = idx_reg;
        row_next      = row_reg;
        rdv_next      = 1'b0;
        zero_next     = zero_reg;
        sign_next     = sign_reg;
        taken_next    = taken_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        found_next    = found_reg;
        t_next        = t_reg;
        take_next     = take_reg;
        sbv_next      = 1'b0;
        sbi_next      = sbi_reg;
        pend_st_next  = pend_st_reg;
        pend_ei_next  = pend_ei_reg;
        pend_sc_next  = pend_sc_reg;
        pend_lr_next  = pend_lr_reg;
        kind_next     = kind_reg;

        ov_next = ov_reg && out_stall;
        st_next = st_reg;
        ei_next = ei_reg;
        sc_next = sc_reg;
        lr_next = lr_reg;

        stg_we = 1'b0;
        stg_wa = elem_cnt_reg[IDX_W-1:0];
        stg_wd = element_value;
        stg_ra = idx_reg[IDX_W-1:0];
        rs_we  = 1'b0;
        rs_wa  = {rows_reg[ROW_W-1:0], idx_reg[IDX_W-1:0]};
        rs_ra  = {row_reg[ROW_W-1:0], idx_reg[IDX_W-1:0]};
        sb_we  = 1'b0;
        sb_wa  = row_reg[ROW_W-1:0];
        sb_ra  = row_reg[ROW_W-1:0];

        mac_ctl.clr = 1'b0;
        mac_ctl.vld = rdv_reg;
        sqrt_start  = 1'b0;
        div_start   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (operation)
                        OP_CLEAR:
                        begin
                            dim_next      = '0;
                            rows_next     = '0;
                            elem_cnt_next = '0;
                            ovf_next      = 1'b0;
                            pend_st_next  = ST_CLEARED;
                            pend_ei_next  = '0;
                            pend_sc_next  = '0;
                            pend_lr_next  = 1'b1;
                            kind_next     = EK_STATUS;
                            state_next    = S_EMIT;
                        end
                        OP_ADD, OP_QUERY:
                        begin
                            if (has_room)
                            begin
                                stg_we        = 1'b1;
                                elem_cnt_next = elem_cnt_reg + CNT_W'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                            if (last_element)
                            begin
                                vlen_next     = has_room ? elem_cnt_reg + CNT_W'(1)
                                                         : elem_cnt_reg;
                                vovf_next     = ovf_reg || !has_room;
                                isq_next      = (operation == OP_QUERY);
                                k_next        = top_k;
                                elem_cnt_next = '0;
                                ovf_next      = 1'b0;
                                state_next    = S_CHECK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_CHECK:
            begin
                pend_ei_next = '0;
                pend_sc_next = '0;
                pend_lr_next = 1'b1;
                kind_next    = EK_STATUS;
                state_next   = S_EMIT;
                if (isq_reg)
                begin
                    if (rows_reg == '0)
                    begin
                        pend_st_next = ST_BANK_EMPTY;
                    end
                    else if (vovf_reg)
                    begin
                        pend_st_next = ST_TOO_LONG;
                    end
                    else if (vlen_reg != dim_reg)
                    begin
                        pend_st_next = ST_DIM_MISMATCH;
                    end
                    else
                    begin
                        state_next = S_SUMSQ;
                    end
                end
                else
                begin
                    if (vovf_reg)
                    begin
                        pend_st_next = ST_TOO_LONG;
                    end
                    else if ((dim_reg != '0) && (vlen_reg != dim_reg))
                    begin
                        pend_st_next = ST_DIM_MISMATCH;
                    end
                    else if (rows_reg >= RCNT_W'(ENTRIES))
                    begin
                        pend_st_next = ST_BANK_FULL;
                    end
                    else
                    begin
                        if (dim_reg == '0)
                        begin
                            dim_next = vlen_reg;
                        end
                        state_next = S_SUMSQ;
                    end
                end
                if (state_next == S_SUMSQ)
                begin
                    idx_next    = '0;
                    mac_ctl.clr = 1'b1;
                end
            end

            S_SUMSQ:
            begin
                if (idx_reg < vlen_reg)
                begin
                    rdv_next = 1'b1;
                    idx_next = idx_reg + CNT_W'(1);
                end
                else if (!rdv_reg && !mac_busy)
                begin
                    sqrt_start = 1'b1;
                    zero_next  = (mac_acc == '0);
                    state_next = S_SQRT;
                end
            end

            S_SQRT:
            begin
                if (!sqrt_busy)
                begin
                    idx_next   = '0;
                    state_next = S_NRM_RD;
                end
            end

            S_NRM_RD:
            begin
                if (idx_reg < vlen_reg)
                begin
                    state_next = S_NRM_DAT;
                end
                else if (isq_reg)
                begin
                    idx_next    = '0;
                    row_next    = '0;
                    mac_ctl.clr = 1'b1;
                    state_next  = S_DOT_RUN;
                end
                else
                begin
                    pend_st_next = ST_ADDED;
                    pend_ei_next = 6'(rows_reg);
                    pend_sc_next = '0;
                    pend_lr_next = 1'b1;
                    kind_next    = EK_ADDED;
                    state_next   = S_EMIT;
                end
            end

            S_NRM_DAT:
            begin
                sign_next = stg_rd_reg[15];
                if (zero_reg)
                begin
                    state_next = S_NRM_WR;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_NRM_DIV;
                end
            end

            S_NRM_DIV:
            begin
                if (!div_stat.busy)
                begin
                    state_next = S_NRM_WR;
                end
            end

            S_NRM_WR:
            begin
                if (isq_reg)
                begin
                    stg_we = 1'b1;
                    stg_wa = idx_reg[IDX_W-1:0];
                    stg_wd = y;
                end
                else
                begin
                    rs_we = 1'b1;
                end
                idx_next   = idx_reg + CNT_W'(1);
                state_next = S_NRM_RD;
            end

            S_DOT_RUN:
            begin
                if (idx_reg < vlen_reg)
                begin
                    rdv_next = 1'b1;
                    idx_next = idx_reg + CNT_W'(1);
                end
                else if (!rdv_reg && !mac_busy)
                begin
                    state_next = S_DOT_SAVE;
                end
            end

            S_DOT_SAVE:
            begin
                sb_we = 1'b1;
                taken_next[row_reg[ROW_W-1:0]] = 1'b0;
                mac_ctl.clr = 1'b1;
                idx_next    = '0;
                if ((row_reg + RCNT_W'(1)) == rows_reg)
                begin
                    row_next   = '0;
                    t_next     = '0;
                    found_next = 1'b0;
                    take_next  = tk;
                    state_next = S_RANK_SCAN;
                end
                else
                begin
                    row_next   = row_reg + RCNT_W'(1);
                    state_next = S_DOT_RUN;
                end
            end

            S_RANK_SCAN:
            begin
                // Strictly greater keeps the lower row on equal scores.
                if (sbv_reg && !taken_reg[sbi_reg] && (!found_reg || (sb_rd_reg > best_reg)))
                begin
                    best_next     = sb_rd_reg;
                    best_idx_next = sbi_reg;
                    found_next    = 1'b1;
                end
                if (row_reg < rows_reg)
                begin
                    sbv_next = 1'b1;
                    sbi_next = row_reg[ROW_W-1:0];
                    row_next = row_reg + RCNT_W'(1);
                end
                else if (!sbv_reg)
                begin
                    pend_st_next = ST_MATCH;
                    pend_ei_next = 6'(best_idx_reg);
                    pend_sc_next = best_reg;
                    pend_lr_next = ((t_reg + TAKE_W'(1)) == take_reg);
                    kind_next    = EK_MATCH;
                    state_next   = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    st_next = pend_st_reg;
                    ei_next = pend_ei_reg;
                    sc_next = pend_sc_reg;
                    lr_next = pend_lr_reg;
                    case (kind_reg)
                        EK_ADDED:
                        begin
                            rows_next  = rows_reg + RCNT_W'(1);
                            state_next = S_IDLE;
                        end
                        EK_MATCH:
                        begin
                            taken_next[best_idx_reg] = 1'b1;
                            t_next = t_reg + TAKE_W'(1);
                            if (pend_lr_reg)
                            begin
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                row_next   = '0;
                                found_next = 1'b0;
                                state_next = S_RANK_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_cnt_reg <= '0;
            ovf_reg      <= 1'b0;
            dim_reg      <= '0;
            rows_reg     <= '0;
            vlen_reg     <= '0;
            vovf_reg     <= 1'b0;
            isq_reg      <= 1'b0;
            k_reg        <= '0;
            idx_reg      <= '0;
            row_reg      <= '0;
            rdv_reg      <= 1'b0;
            zero_reg     <= 1'b0;
            sign_reg     <= 1'b0;
            taken_reg    <= '0;
            best_reg     <= '0;
            best_idx_reg <= '0;
            found_reg    <= 1'b0;
            t_reg        <= '0;
            take_reg     <= '0;
            sbv_reg      <= 1'b0;
            sbi_reg      <= '0;
            pend_st_reg  <= ST_MATCH;
            pend_ei_reg  <= '0;
            pend_sc_reg  <= '0;
            pend_lr_reg  <= 1'b0;
            kind_reg     <= EK_STATUS;
            ov_reg       <= 1'b0;
            st_reg       <= '0;
            ei_reg       <= '0;
            sc_reg       <= '0;
            lr_reg       <= 1'b0;
        end
        else
        begin
            elem_cnt_reg <= elem_cnt_next;
            ovf_reg      <= ovf_next;
            dim_reg      <= dim_next;
            rows_reg     <= rows_next;
            vlen_reg     <= vlen_next;
            vovf_reg     <= vovf_next;
            isq_reg      <= isq_next;
            k_reg        <= k_next;
            idx_reg      <= idx_next;
            row_reg      <= row_next;
            rdv_reg      <= rdv_next;
            zero_reg     <= zero_next;
            sign_reg     <= sign_next;
            taken_reg    <= taken_next;
            best_reg     <= best_next;
            best_idx_reg <= best_idx_next;
            found_reg    <= found_next;
            t_reg        <= t_next;
            take_reg     <= take_next;
            sbv_reg      <= sbv_next;
            sbi_reg      <= sbi_next;
            pend_st_reg  <= pend_st_next;
            pend_ei_reg  <= pend_ei_next;
            pend_sc_reg  <= pend_sc_next;
            pend_lr_reg  <= pend_lr_next;
            kind_reg     <= kind_next;
            ov_reg       <= ov_next;
            st_reg       <= st_next;
            ei_reg       <= ei_next;
            sc_reg       <= sc_next;
            lr_reg       <= lr_next;
        end
    end

    assign out_valid   = ov_reg;
    assign status      = st_reg;
    assign entry_index = ei_reg;
    assign score       = sc_reg;
    assign last_result = lr_reg;

endmodule

`default_nettype wire

FILE: sv/ebtk_checker.sv
// Port-level checker for the embedding bank search, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module ebtk_checker
    import ebtk_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [1:0]         operation,
    input logic               out_valid,
    input logic               out_stall,
    input logic [2:0]         status,
    input logic [5:0]         entry_index,
    input logic signed [15:0] score,
    input logic               last_result
);

    logic status_beat;
    logic clear_beat;

    assign status_beat = out_valid && (status != ST_MATCH);
    assign clear_beat  = in_valid && !in_stall && (operation == OP_CLEAR);

    `EBTK_ASSERT_HOLD(a_out_hold, clk, rst_n, out_valid, out_stall)
    `EBTK_ASSERT(a_status_last, clk, rst_n, status_beat |-> last_result)
    `EBTK_ASSERT(a_status_score, clk, rst_n, status_beat |-> (score == 16'sd0))
    `EBTK_ASSERT(a_status_index, clk, rst_n, (status_beat && (status != ST_ADDED)) |-> (entry_index == 6'd0))
    `EBTK_ASSERT(a_clear_busy, clk, rst_n, clear_beat |=> in_stall)

endmodule

bind embedding_bank_top_k_search ebtk_checker u_ebtk_checker (.*);

`default_nettype wire
